@@ rtl/core/recent_history_list_assert.svh @@
// ----------------------------------------------------------------------------
// Recent history list - assertion macros
// Clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECENT_HISTORY_LIST_ASSERT_SVH
`define RECENT_HISTORY_LIST_ASSERT_SVH

// property must hold at every edge out of reset
`define RHL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("recent_history_list: assertion failed");

// condition must never be seen out of reset
`define RHL_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("recent_history_list: forbidden condition seen");

`endif

@@ rtl/core/rhl_pkg.sv @@
// ----------------------------------------------------------------------------
// rhl_pkg
// Shared types and constants of the recent history list.
// ----------------------------------------------------------------------------
package rhl_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] article_number;
        logic [11:0] first_line;
        logic [7:0]  ref_code;
        logic [3:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  entry_count;
        logic        duplicate_removed;
        logic        oldest_dropped;
        logic        read_valid;
        logic [15:0] read_number;
        logic [11:0] read_first_line;
        logic [7:0]  read_ref_code;
    } t_out_word;

    // one stored list entry
    typedef struct packed {
        logic [15:0] number;
        logic [11:0] position;
        logic [7:0]  code;
    } t_entry;

endpackage

@@ rtl/core/rhl_if.sv @@
// ----------------------------------------------------------------------------
// rhl_in_if / rhl_out_if
// Valid/ready channels carrying command and result words.
// ----------------------------------------------------------------------------
interface rhl_in_if;
    logic             valid;
    logic             ready;
    rhl_pkg::t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rhl_out_if;
    logic              valid;
    logic              ready;
    rhl_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/recent_history_list.sv @@
// ----------------------------------------------------------------------------
// recent_history_list
// Bounded most-recently-used list held in one synchronous RAM.
// ----------------------------------------------------------------------------
// The list is kept oldest first in a single-port-write, registered-read RAM
// of HISTORY_DEPTH entries. One command word is taken at a time; its result
// word goes to an output register, so the next command is accepted while a
// result still waits. Work per word, N being the entry count:
//   clear / no-op : straight to the result
//   read          : one RAM read, then the result
//   append        : compare-and-shift walk over the N entries, write of the
//                   new entry and result, plus a shift pass to drop the
//                   oldest entry when the list is full and no duplicate
//                   was found.
// The walk is set by the RAM: one entry is read per cycle and, once the
// matching entry has been found, each later entry is written back one slot
// lower, one entry behind the read, so the two never hit the same address.
// No clearing pass is needed after reset: only entries below the count are
// ever read back, and the count resets to zero.
// ----------------------------------------------------------------------------
`include "recent_history_list_assert.svh"

module recent_history_list #(
    parameter int HISTORY_DEPTH = rhl_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rhl_in_if.sink         i_in,
    rhl_out_if.source      o_out
);

    localparam int AW = $clog2(HISTORY_DEPTH);       // RAM address width
    localparam int CW = $clog2(HISTORY_DEPTH + 1);   // count width, holds depth

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,   // compare / shift walk over the list
        S_WRITE = 4'b0100,   // new entry goes to the tail
        S_FIN   = 4'b1000    // result word into output register
    } t_state;

    // ---- storage ----
    rhl_pkg::t_entry r_mem [HISTORY_DEPTH];
    rhl_pkg::t_entry r_mem_q;                        // registered read data

    // ---- control ----
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_ptr, n_ptr;                 // next entry to read
    logic              r_pend, n_pend;               // r_mem_q holds walk data
    logic [AW-1:0]     r_pend_idx, n_pend_idx;       // index of that data
    logic              r_shift, n_shift;             // entries now move down
    logic              r_dup, n_dup;
    logic              r_drop, n_drop;
    logic              r_rvalid, n_rvalid;
    logic              r_out_valid;

    // ---- latched command ----
    rhl_pkg::t_opcode  r_op;
    logic [15:0]       r_num;
    logic [11:0]       r_pos;
    logic [7:0]        r_code;
    rhl_pkg::t_out_word r_out;

    // ---- RAM port controls ----
    logic              w_re, w_we;
    logic [AW-1:0]     w_raddr, w_waddr;
    rhl_pkg::t_entry   w_wdata;

    logic              w_accept;
    logic              w_out_load;
    logic              w_issue;
    logic [CW-1:0]     w_base;                       // tail slot for append
    logic [CW+3:0]     w_idx_ext;
    logic [CW+3:0]     w_cnt_ext;
    logic [CW+4:0]     w_cnt_wide;
    rhl_pkg::t_out_word w_result;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_load  = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign w_issue     = (r_state == S_WALK) && (r_ptr < r_cnt);

    assign w_idx_ext   = {{CW{1'b0}}, i_in.payload.read_index};
    assign w_cnt_ext   = {4'b0000, r_cnt};
    assign w_cnt_wide  = {5'b00000, r_cnt};

    // slot of the new entry: the tail, one lower when a duplicate was removed, or last slot after a drop
    assign w_base = r_drop ? CW'(HISTORY_DEPTH - 1) : (r_cnt - CW'(r_dup));

    // ---- next-state logic ----
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_shift    = r_shift;
        n_dup      = r_dup;
        n_drop     = r_drop;
        n_rvalid   = r_rvalid;
        w_re       = 1'b0;
        w_raddr    = r_ptr[AW-1:0];
        w_we       = 1'b0;
        w_waddr    = w_base[AW-1:0];
        w_wdata    = '{number: r_num, position: r_pos, code: r_code};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_dup    = 1'b0;
                    n_drop   = 1'b0;
                    n_shift  = 1'b0;
                    n_rvalid = 1'b0;
                    case (i_in.payload.opcode)
                        rhl_pkg::OP_APPEND: begin
                            n_ptr   = '0;
                            n_state = S_WALK;
                        end
                        rhl_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_FIN;
                        end
                        rhl_pkg::OP_READ: begin
                            w_re     = 1'b1;
                            w_raddr  = w_idx_ext[AW-1:0];
                            n_rvalid = (w_idx_ext < w_cnt_ext);
                            n_state  = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue the next read
                if (w_issue) begin
                    w_re       = 1'b1;
                    w_raddr    = r_ptr[AW-1:0];
                    n_ptr      = r_ptr + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[AW-1:0];
                end
                // consume the data read last cycle
                if (r_pend) begin
                    if (r_shift) begin
                        w_we    = 1'b1;
                        w_waddr = r_pend_idx - 1'b1;
                        w_wdata = r_mem_q;
                    end else if (r_mem_q.number == r_num) begin
                        n_shift = 1'b1;
                        n_dup   = 1'b1;
                    end
                end
                // walk finished
                if (!w_issue && !r_pend) begin
                    if (!r_dup && !r_drop && (r_cnt == CW'(HISTORY_DEPTH))) begin
                        // full, no duplicate: shift everything down from entry 1
                        n_drop  = 1'b1;
                        n_shift = 1'b1;
                        n_ptr   = CW'(1);
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end

            S_WRITE: begin
                w_we    = 1'b1;
                n_cnt   = w_base + 1'b1;
                n_state = S_FIN;
            end

            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- result word ----
    always_comb begin
        w_result                   = '0;
        w_result.entry_count       = w_cnt_wide[4:0];
        w_result.duplicate_removed = (r_op == rhl_pkg::OP_APPEND) && r_dup;
        w_result.oldest_dropped    = (r_op == rhl_pkg::OP_APPEND) && r_drop;
        if ((r_op == rhl_pkg::OP_READ) && r_rvalid) begin
            w_result.read_valid      = 1'b1;
            w_result.read_number     = r_mem_q.number;
            w_result.read_first_line = r_mem_q.position;
            w_result.read_ref_code   = r_mem_q.code;
        end
    end

    // ---- RAM ----
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_shift  <= 1'b0;
            r_dup    <= 1'b0;
            r_drop   <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_shift  <= n_shift;
            r_dup    <= n_dup;
            r_drop   <= n_drop;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        if (w_accept) begin
            r_op   <= i_in.payload.opcode;
            r_num  <= i_in.payload.article_number;
            r_pos  <= i_in.payload.first_line;
            r_code <= i_in.payload.ref_code;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // ---- assertions ----
    `RHL_ASSERT(a_cnt_bound, r_cnt <= CW'(HISTORY_DEPTH))
    `RHL_NEVER(a_dup_and_drop, r_dup && r_drop)
    `RHL_ASSERT(a_tail_written, (r_state == S_WRITE) |=> (r_cnt != '0))
    `RHL_NEVER(a_shift_below_zero, (r_state == S_WALK) && r_pend && r_shift && (r_pend_idx == '0))

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - recent history list testbench
// Drives command words into the history list and checks every result word
// against an in-bench model of the list: duplicate removal, eviction of the
// oldest entry when full, clear, reads in and out of range, and the unused
// opcode. Directed words first, then random bursts under varying
// backpressure, including one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import rhl_pkg::*;

    localparam int DEPTH          = DEFAULT_HISTORY_DEPTH;
    localparam int RANDOM_WORDS   = 600;
    localparam int HOLD_CYCLES    = 300;   // long receiver stall, fills the block up
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 60;    // longer than the worst append

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the list and the queue of result
    // words still owed by the block.
    // ------------------------------------------------------------------------
    class history_scoreboard;
        t_entry      entries [DEPTH];
        int unsigned live_count;
        t_out_word   owed_results [$];
        int unsigned failures;

        function new();
            live_count = 0;
            failures   = 0;
        endfunction

        // work out the result of an accepted command and update the list
        function void note_command(t_in_word w);
            t_out_word r;
            int        hit;
            r   = '0;
            hit = -1;
            case (w.opcode)
                OP_APPEND: begin
                    for (int i = 0; i < live_count; i++)
                        if (hit < 0 && entries[i].number == w.article_number) hit = i;
                    // matching entry leaves, later ones close the gap
                    if (hit >= 0) begin
                        for (int j = hit; j + 1 < live_count; j++) entries[j] = entries[j + 1];
                        live_count--;
                        r.duplicate_removed = 1'b1;
                    end
                    // still full: oldest goes
                    if (live_count >= DEPTH) begin
                        for (int j = 0; j + 1 < live_count; j++) entries[j] = entries[j + 1];
                        live_count = DEPTH - 1;
                        r.oldest_dropped = 1'b1;
                    end
                    entries[live_count].number   = w.article_number;
                    entries[live_count].position = w.first_line;
                    entries[live_count].code     = w.ref_code;
                    live_count++;
                end
                OP_CLEAR: live_count = 0;
                OP_READ: begin
                    if (w.read_index < live_count) begin
                        r.read_valid      = 1'b1;
                        r.read_number     = entries[w.read_index].number;
                        r.read_first_line = entries[w.read_index].position;
                        r.read_ref_code   = entries[w.read_index].code;
                    end
                end
                default: ;  // unused opcode leaves the list alone
            endcase
            r.entry_count = 5'(live_count);
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (owed_results.size() == 0) begin
                $error("result word with no command outstanding: %h", got);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("entry_count",
                          32'(want.entry_count), 32'(got.entry_count));
            compare_field("duplicate_removed",
                          32'(want.duplicate_removed), 32'(got.duplicate_removed));
            compare_field("oldest_dropped",
                          32'(want.oldest_dropped), 32'(got.oldest_dropped));
            compare_field("read_valid",
                          32'(want.read_valid), 32'(got.read_valid));
            compare_field("read_number",
                          32'(want.read_number), 32'(got.read_number));
            compare_field("read_first_line",
                          32'(want.read_first_line), 32'(got.read_first_line));
            compare_field("read_ref_code",
                          32'(want.read_ref_code), 32'(got.read_ref_code));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rhl_in_if  in_ch ();
    rhl_out_if out_ch ();

    recent_history_list #(
        .HISTORY_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    history_scoreboard book = new();

    // idling mix, moved on by the stimulus as the random part progresses
    int src_idle_pct = 28;
    int snk_idle_pct = 52;
    int phase        = 0;

    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off when the no-idle phase
    // starts, so that the output register fills and the input stalls.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) book.check_result(out_ch.payload);
    end

    // watchdog: ends the run if no word moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one command word, with random idle cycles ahead of it; entered and
    // left at a falling edge
    task automatic send_command(input t_opcode op, input logic [15:0] num,
                                input logic [11:0] line, input logic [7:0] code,
                                input logic [3:0] idx);
        t_in_word w;
        w.opcode         = op;
        w.article_number = num;
        w.first_line     = line;
        w.ref_code       = code;
        w.read_index     = idx;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.payload <= w;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        book.note_command(w);
        @(negedge i_clk);
    endtask

    // unused fields carry random values so the block is seen to ignore them
    task automatic send_append(input logic [15:0] num);
        send_command(OP_APPEND, num, 12'($urandom), 8'($urandom), 4'($urandom));
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_command(OP_READ, 16'($urandom), 12'($urandom), 8'($urandom), idx);
    endtask

    task automatic send_other(input t_opcode op);
        send_command(op, 16'($urandom), 12'($urandom), 8'($urandom), 4'($urandom));
    endtask

    // number for a churn append: often one already in the list, to force
    // duplicate removal, otherwise from a small pool
    function automatic logic [15:0] churn_number(input logic [15:0] pool_base);
        if (book.live_count != 0 && $urandom_range(1) == 1)
            return book.entries[$urandom_range(book.live_count - 1)].number;
        return pool_base + 16'($urandom_range(5));
    endfunction

    initial begin
        int          sent;
        int          burst;
        int          kind;
        logic [15:0] pool_base;

        sent            = 0;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.payload   = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part -------------------------------------------------
        send_read(4'd0);                                        // read on empty list
        send_other(OP_NOP);
        send_command(OP_APPEND, 16'h0000, 12'h000, 8'h00, 4'hF);
        send_command(OP_APPEND, 16'hFFFF, 12'hFFF, 8'hFF, 4'h0);
        send_command(OP_APPEND, 16'h5A5A, 12'hA5A, 8'h5A, 4'h7);
        send_command(OP_APPEND, 16'h0000, 12'h123, 8'h81, 4'h3); // dup, moves to tail
        send_read(4'd0);
        send_read(4'd1);
        send_read(4'd2);
        send_read(4'd3);                                        // just past the end
        send_read(4'd15);
        send_command(OP_APPEND, 16'hFFFF, 12'h800, 8'h7E, 4'h8); // dup at the head
        send_read(4'd2);
        send_other(OP_CLEAR);
        send_read(4'd0);                                        // stale entry not returned
        send_other(OP_CLEAR);                                   // clear of an empty list
        send_append(16'h8001);
        send_read(4'd0);
        send_other(OP_NOP);

        // --- random part ---------------------------------------------------
        // fill bursts push the list past full, churn hits duplicates,
        // with reads, clears and unused opcodes in between
        while (sent < RANDOM_WORDS) begin
            phase = (sent * 3) / RANDOM_WORDS;
            case (phase)
                0:       begin src_idle_pct = 28; snk_idle_pct = 52; end
                1:       begin src_idle_pct = 52; snk_idle_pct = 28; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            kind = $urandom_range(9);
            if (kind < 3) begin
                burst = $urandom_range(22, 14);
                repeat (burst) send_append(16'($urandom));
                sent += burst;
                burst = $urandom_range(5, 2);
                repeat (burst) send_read(4'($urandom));
                sent += burst;
            end else if (kind < 7) begin
                pool_base = 16'($urandom);
                burst     = $urandom_range(16, 6);
                repeat (burst) begin
                    case ($urandom_range(19)) inside
                        0:       send_other(OP_NOP);
                        [1:7]:   send_read(4'($urandom));
                        default: send_append(churn_number(pool_base));
                    endcase
                    sent++;
                end
            end else if (kind < 9) begin
                burst = $urandom_range(8, 3);
                repeat (burst) send_read(4'($urandom));
                sent += burst;
            end else begin
                send_other(OP_CLEAR);
                send_other(OP_NOP);
                sent++;
            end
        end
        in_ch.valid <= 1'b0;

        // --- drain ---------------------------------------------------------
        while (book.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.failures == 0 && book.owed_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
